>>> rtl/dicom_tag_stream_parser_assert.svh
// Assertion macros for the tag stream parser checker.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DICOM_TAG_STREAM_PARSER_ASSERT_SVH
`define DICOM_TAG_STREAM_PARSER_ASSERT_SVH

// General property check on the block clock.
`define DTSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A stalled transaction keeps its valid and its payload until it is taken.
`define DTSP_ASSERT_HOLD(lbl, vld, rdy, pld, msg) \
  `DTSP_ASSERT(lbl, (vld) && !(rdy) |=> (vld) && $stable(pld), msg)

`endif

>>> rtl/dtsp_pkg.sv
// Shared types, constants and tag lookup for the tag stream parser.
// No dependencies; used by every module of the block.
package dtsp_pkg;

  localparam logic [7:0] PREAMBLE_BYTES = 8'd128;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  field_code;
    logic [15:0] value;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_PREAMBLE,
    PH_MAGIC,
    PH_HEADER,
    PH_SCAN,
    PH_SKIP,
    PH_VALUE,
    PH_STOPPED
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_STRING,
    KIND_USHORT,
    KIND_PIXEL
  } kind_e;

  localparam logic [3:0] FC_NAME       = 4'd0;
  localparam logic [3:0] FC_ID         = 4'd1;
  localparam logic [3:0] FC_ROWS       = 4'd2;
  localparam logic [3:0] FC_COLS       = 4'd3;
  localparam logic [3:0] FC_SPACING    = 4'd4;
  localparam logic [3:0] FC_THICKNESS  = 4'd5;
  localparam logic [3:0] FC_POSITION   = 4'd6;
  localparam logic [3:0] FC_INSTANCE   = 4'd7;
  localparam logic [3:0] FC_BITSALLOC  = 4'd8;
  localparam logic [3:0] FC_BITSSTORED = 4'd9;
  localparam logic [3:0] FC_PIXREP     = 4'd10;
  localparam logic [3:0] FC_INTERCEPT  = 4'd11;
  localparam logic [3:0] FC_SLOPE      = 4'd12;
  localparam logic [3:0] FC_PIXEL      = 4'd13;
  localparam logic [3:0] FC_MAGIC      = 4'd14;

  localparam logic [15:0] GRP_PATIENT = 16'h0010;
  localparam logic [15:0] GRP_ACQ     = 16'h0018;
  localparam logic [15:0] GRP_REL     = 16'h0020;
  localparam logic [15:0] GRP_IMAGE   = 16'h0028;
  localparam logic [15:0] GRP_PIXEL   = 16'h7FE0;
  localparam logic [31:0] UNDEF_LEN   = 32'hFFFF_FFFF;
  localparam logic [23:0] DELIM_HEAD  = 24'hFE_FFDD;
  localparam logic [7:0]  DELIM_TAIL  = 8'hE0;
  localparam logic [31:0] DELIM_LEN   = 32'd4;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] code;
  } tag_class_t;

  function automatic tag_class_t classify_tag(logic [15:0] grp, logic [15:0] elem);
    tag_class_t r;
    r = '{kind: KIND_SKIP, code: FC_NAME};
    if (grp == GRP_PATIENT && elem == 16'h0010) r = '{KIND_STRING, FC_NAME};
    else if (grp == GRP_PATIENT && elem == 16'h0020) r = '{KIND_STRING, FC_ID};
    else if (grp == GRP_IMAGE && elem == 16'h0010) r = '{KIND_USHORT, FC_ROWS};
    else if (grp == GRP_IMAGE && elem == 16'h0011) r = '{KIND_USHORT, FC_COLS};
    else if (grp == GRP_IMAGE && elem == 16'h0030) r = '{KIND_STRING, FC_SPACING};
    else if (grp == GRP_ACQ && elem == 16'h0050) r = '{KIND_STRING, FC_THICKNESS};
    else if (grp == GRP_REL && elem == 16'h0032) r = '{KIND_STRING, FC_POSITION};
    else if (grp == GRP_REL && elem == 16'h0013) r = '{KIND_STRING, FC_INSTANCE};
    else if (grp == GRP_IMAGE && elem == 16'h0100) r = '{KIND_USHORT, FC_BITSALLOC};
    else if (grp == GRP_IMAGE && elem == 16'h0101) r = '{KIND_USHORT, FC_BITSSTORED};
    else if (grp == GRP_IMAGE && elem == 16'h0103) r = '{KIND_USHORT, FC_PIXREP};
    else if (grp == GRP_IMAGE && elem == 16'h1052) r = '{KIND_STRING, FC_INTERCEPT};
    else if (grp == GRP_IMAGE && elem == 16'h1053) r = '{KIND_STRING, FC_SLOPE};
    else if (grp == GRP_PIXEL && elem == 16'h0010) r = '{KIND_PIXEL, FC_PIXEL};
    return r;
  endfunction

  // OB, OW, SQ and UN carry two pad bytes and a 32-bit length.
  function automatic logic is_long_vr(logic [15:0] vr);
    return vr == 16'h4F42 || vr == 16'h4F57 || vr == 16'h5351 || vr == 16'h554E;
  endfunction

  function automatic logic [7:0] magic_byte(logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h44;
      2'd1:    r = 8'h49;
      2'd2:    r = 8'h43;
      default: r = 8'h4D;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/dtsp_front.sv
// Front end: takes one byte per transaction, tracks the parse state and
// classifies tags, producing at most one result per byte. Uses dtsp_pkg.
module dtsp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               header_mode_i,
  input  logic               take_i,
  input  dtsp_pkg::in_item_t item_i,
  output logic               push_o,
  output dtsp_pkg::out_item_t result_o
);
  import dtsp_pkg::*;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  pre_cnt;
    logic        magic_ok;
    logic [3:0]  hdr_idx;
    logic [15:0] grp;
    logic [15:0] elem;
    logic [15:0] vr;
    logic [31:0] vlen;
    logic [31:0] left;
    logic [3:0]  field;
    kind_e       kind;
    logic [7:0]  low;
    logic [23:0] win;
    logic        par;
  } parse_state_t;

  localparam phase_e PhaseStart = (PREAMBLE_BYTES != 8'd0) ? PH_PREAMBLE : PH_MAGIC;

  localparam parse_state_t StateReset = '{
    phase:    PhaseStart,
    pre_cnt:  8'd0,
    magic_ok: 1'b1,
    hdr_idx:  4'd0,
    grp:      16'h0000,
    elem:     16'h0000,
    vr:       16'h0000,
    vlen:     32'd0,
    left:     32'd0,
    field:    4'd0,
    kind:     KIND_SKIP,
    low:      8'd0,
    win:      24'd0,
    par:      1'b0
  };

  parse_state_t st_q, st_d, cur;
  logic [7:0]   b;
  logic         emit;
  out_item_t    res;
  logic         do_dispatch;
  logic [31:0]  dlen;
  logic [31:0]  pos;
  logic         last_b;
  logic [1:0]   midx;
  logic         mok;
  tag_class_t   tcls;

  assign b    = item_i.data_byte;
  assign tcls = classify_tag(cur.grp, cur.elem);
  assign pos  = cur.vlen - cur.left;

  always_comb begin
    cur = st_q;
    if (item_i.first_byte) begin
      cur          = '0;
      cur.phase    = header_mode_i ? PhaseStart : PH_HEADER;
      cur.magic_ok = 1'b1;
      cur.kind     = KIND_SKIP;
    end
  end

  always_comb begin
    st_d        = cur;
    emit        = 1'b0;
    res         = '0;
    do_dispatch = 1'b0;
    dlen        = cur.vlen;
    last_b      = (cur.left == 32'd1);
    midx        = cur.hdr_idx[1:0];
    mok         = cur.magic_ok & (b == magic_byte(midx));
    case (cur.phase)
      PH_PREAMBLE: begin
        st_d.pre_cnt = cur.pre_cnt + 8'd1;
        if (st_d.pre_cnt >= PREAMBLE_BYTES) st_d.phase = PH_MAGIC;
      end
      PH_MAGIC: begin
        st_d.magic_ok = mok;
        if (midx == 2'd3) begin
          st_d.hdr_idx = '0;
          st_d.phase   = PH_HEADER;
          if (!mok) begin
            emit = 1'b1;
            res  = '{field_code: FC_MAGIC, value: 16'h0000, last: 1'b1};
          end
        end else begin
          st_d.hdr_idx = {2'b00, midx + 2'd1};
        end
      end
      PH_HEADER: begin
        case (cur.hdr_idx)
          4'd0: st_d.grp = {8'h00, b};
          4'd1: st_d.grp = cur.grp | {b, 8'h00};
          4'd2: st_d.elem = {8'h00, b};
          4'd3: st_d.elem = cur.elem | {b, 8'h00};
          4'd4: st_d.vr = {b, 8'h00};
          4'd5: st_d.vr = cur.vr | {8'h00, b};
          4'd6: st_d.vlen = {24'h0, b};
          4'd7: begin
            dlen      = cur.vlen | {16'h0, b, 8'h00};
            st_d.vlen = dlen;
            do_dispatch = !is_long_vr(cur.vr);
          end
          4'd8:  st_d.vlen = {24'h0, b};
          4'd9:  st_d.vlen = cur.vlen | {16'h0, b, 8'h00};
          4'd10: st_d.vlen = cur.vlen | {8'h00, b, 16'h0};
          default: begin
            dlen        = cur.vlen | {b, 24'h0};
            st_d.vlen   = dlen;
            do_dispatch = 1'b1;
          end
        endcase
        if (do_dispatch) begin
          st_d.hdr_idx = '0;
          st_d.left    = dlen;
          if (dlen == UNDEF_LEN) begin
            st_d.win   = '0;
            st_d.par   = 1'b0;
            st_d.phase = PH_SCAN;
          end else begin
            st_d.field = tcls.code;
            st_d.kind  = tcls.kind;
            if (tcls.kind == KIND_SKIP) begin
              st_d.phase = (dlen != 32'd0) ? PH_SKIP : PH_HEADER;
            end else if (dlen == 32'd0) begin
              st_d.phase = (tcls.kind == KIND_PIXEL) ? PH_STOPPED : PH_HEADER;
            end else begin
              st_d.phase = PH_VALUE;
            end
          end
        end else begin
          st_d.hdr_idx = cur.hdr_idx + 4'd1;
        end
      end
      PH_SCAN: begin
        // The delimiter only counts when it starts on an even offset.
        if (cur.par && cur.win == DELIM_HEAD && b == DELIM_TAIL) begin
          st_d.left  = DELIM_LEN;
          st_d.phase = PH_SKIP;
        end else begin
          st_d.win = {cur.win[15:0], b};
          st_d.par = ~cur.par;
        end
      end
      PH_SKIP: begin
        st_d.left = cur.left - 32'd1;
        if (last_b) st_d.phase = PH_HEADER;
      end
      PH_VALUE: begin
        st_d.left = cur.left - 32'd1;
        if (last_b) st_d.phase = (cur.kind == KIND_PIXEL) ? PH_STOPPED : PH_HEADER;
        res.field_code = cur.field;
        case (cur.kind)
          KIND_STRING: begin
            emit = 1'b1;
            res.value = {8'h00, b};
            res.last  = last_b;
          end
          KIND_USHORT: begin
            if (pos == 32'd0) begin
              if (last_b) begin
                emit = 1'b1;
                res.value = {8'h00, b};
                res.last  = 1'b1;
              end else begin
                st_d.low = b;
              end
            end else if (pos == 32'd1) begin
              emit = 1'b1;
              res.value = {b, cur.low};
              res.last  = 1'b1;
            end
          end
          KIND_PIXEL: begin
            if (!pos[0]) begin
              if (last_b) begin
                emit = 1'b1;
                res.value = {8'h00, b};
                res.last  = 1'b1;
              end else begin
                st_d.low = b;
              end
            end else begin
              emit = 1'b1;
              res.value = {b, cur.low};
              res.last  = last_b;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (take_i) begin
      st_q <= st_d;
    end
  end

  assign push_o   = take_i & emit;
  assign result_o = res;

endmodule

>>> rtl/dtsp_queue.sv
// Back end: a short result queue that drives the output channel.
// Uses dtsp_pkg for the result type and the queue depth.
module dtsp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dtsp_pkg::out_item_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtsp_pkg::out_item_t out_o
);
  import dtsp_pkg::*;

  out_item_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     cnt_q, cnt_d;
  logic                   pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign full_o      = (cnt_q == (QueuePtrW + 1)'(QueueDepth));
  assign out_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QueuePtrW + 1)'(push_i) - (QueuePtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/dicom_tag_stream_parser.sv
// Tag stream parser top level: one byte accepted per cycle while the result
// queue has room; each result is registered in the queue and offered from it.
// The parse step is combinational; the parse state is registered per byte.
// Four queued results let the input run on while the output is stalled.
// Reset is asynchronous and active low; header_mode returns to 1 and the
// parser expects the preamble first.
module dicom_tag_stream_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtsp_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtsp_pkg::out_item_t out_o
);
  import dtsp_pkg::*;

  logic      header_mode_q;
  logic      full;
  logic      take;
  logic      push;
  out_item_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      header_mode_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = ~full;
  assign take       = in_valid_i & in_ready_o;

  dtsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .header_mode_i(header_mode_q),
    .take_i       (take),
    .item_i       (in_i),
    .push_o       (push),
    .result_o     (result)
  );

  dtsp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

>>> rtl/dtsp_checker.sv
// Port-level checks for the tag stream parser, bound to the top level.
// Depends on dtsp_pkg and dicom_tag_stream_parser_assert.svh.
`include "dicom_tag_stream_parser_assert.svh"

module dtsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic                cfg_wdata_i,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input dtsp_pkg::in_item_t  in_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dtsp_pkg::out_item_t out_o
);
  import dtsp_pkg::*;

  `DTSP_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, out_o, "output transaction changed while stalled")
  `DTSP_ASSERT(a_code_range, out_valid_o |-> out_o.field_code != 4'hF, "field code out of range")
  `DTSP_ASSERT(a_magic_fmt, out_valid_o && out_o.field_code == FC_MAGIC |-> out_o.value == 16'h0000 && out_o.last, "missing magic result malformed")
  `DTSP_ASSERT(a_ushort_last, out_valid_o && (out_o.field_code == FC_ROWS || out_o.field_code == FC_COLS || out_o.field_code == FC_BITSALLOC || out_o.field_code == FC_BITSSTORED || out_o.field_code == FC_PIXREP) |-> out_o.last, "word field without last")

endmodule

bind dicom_tag_stream_parser dtsp_checker u_dtsp_checker (.*);
